// ----- rtl/tmp_pkg.sv -----
package tmp_pkg;

  // phase codes of a result word
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_STAND   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ACCEL   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CRUISE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DECEL   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REACHED = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST    = 2'd2;

  // cycles from an accepted word to its result strobe
  localparam int EVAL_LATENCY = 5;

endpackage

// ----- rtl/tmp_plan.sv -----
module tmp_plan #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [W-2:0]                    cfg_data,
  output logic                            busy,
  output logic [W-2:0]                    a_eff,
  output logic [W-2:0]                    move_dist,
  output logic [W-2:0]                    ta,
  output logic [W-2:0]                    peak,
  output logic [W-1:0]                    e1,
  output logic [W:0]                      e2,
  output logic [3*(W-1)-1:0]              ata2,
  output logic                            tri_flag
);

  localparam int VW = W - 1;
  localparam int DW = 2 * VW;
  localparam int QW = 2 * VW + 2 * F;
  localparam int RW = QW / 2;
  localparam int CW = $clog2(QW + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VV   = 4'd1;
  localparam logic [3:0] ST_AD   = 4'd2;
  localparam logic [3:0] ST_AV   = 4'd3;
  localparam logic [3:0] ST_PICK = 4'd4;
  localparam logic [3:0] ST_DIV1 = 4'd5;
  localparam logic [3:0] ST_DIV2 = 4'd6;
  localparam logic [3:0] ST_SQ1  = 4'd7;
  localparam logic [3:0] ST_SQ2  = 4'd8;
  localparam logic [3:0] ST_AT   = 4'd9;
  localparam logic [3:0] ST_ATLO = 4'd10;
  localparam logic [3:0] ST_ATHI = 4'd11;

  logic [3:0]      state_r;
  logic [VW-1:0]   vmax_r, amax_r, dist_r;
  logic [DW-1:0]   vv_r, ad_r, av_r, at_r, part_r;
  logic            tri_r;
  logic [QW-1:0]   n_r, sx_r;
  logic [DW-1:0]   rem_r, dv_r;
  logic [RW+1:0]   sr_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic [VW-1:0]   ta_r, tc_r, pk_r;
  logic [3*VW-1:0] ata2_r;
  logic [W-1:0]    e1_r;
  logic [W:0]      e2_r;

  logic [VW-1:0]   v_eff, a_use;
  logic [VW-1:0]   mul_a, mul_b;
  logic [DW-1:0]   mul_p;
  logic            cfg_hit;
  logic [DW:0]     div_trial, div_diff;
  logic            div_ge;
  logic [DW-1:0]   rem_nxt;
  logic [QW-1:0]   n_nxt;
  logic [RW+3:0]   sq_shift, sq_trial, sq_diff;
  logic            sq_ge;
  logic [RW+1:0]   sr_nxt;
  logic [RW-1:0]   root_nxt;
  logic [VW-1:0]   q_sat, root_sat;
  logic [DW-1:0]   ad_minus_vv;
  logic [W-1:0]    e1_sum;

  // zero limits plan as the smallest step
  assign v_eff = (vmax_r == '0) ? VW'(1) : vmax_r;
  assign a_use = (amax_r == '0) ? VW'(1) : amax_r;
  assign cfg_hit = cfg_we && (cfg_index == tmp_pkg::REG_MAX_VEL ||
                              cfg_index == tmp_pkg::REG_MAX_ACC ||
                              cfg_index == tmp_pkg::REG_DIST);

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    unique case (state_r)
      ST_VV:   begin mul_a = v_eff;           mul_b = v_eff;  end
      ST_AD:   begin mul_a = a_use;           mul_b = dist_r; end
      ST_AV:   begin mul_a = a_use;           mul_b = v_eff;  end
      ST_AT:   begin mul_a = a_use;           mul_b = ta_r;   end
      ST_ATLO: begin mul_a = at_r[VW-1:0];    mul_b = ta_r;   end
      ST_ATHI: begin mul_a = at_r[DW-1:VW];   mul_b = ta_r;   end
      default: begin mul_a = '0;              mul_b = '0;     end
    endcase
  end
  assign mul_p = DW'(mul_a) * DW'(mul_b);

  // one restoring division step
  assign div_trial = {rem_r, n_r[QW-1]};
  assign div_ge    = div_trial >= {1'b0, dv_r};
  assign div_diff  = div_trial - {1'b0, dv_r};
  assign rem_nxt   = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
  assign n_nxt     = {n_r[QW-2:0], div_ge};
  assign q_sat     = (|n_nxt[QW-1:VW]) ? {VW{1'b1}} : n_nxt[VW-1:0];

  // one digit of the square root, two radicand bits a step
  assign sq_shift = {sr_r, sx_r[QW-1:QW-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;
  assign sq_diff  = sq_shift - sq_trial;
  assign sr_nxt   = sq_ge ? sq_diff[RW+1:0] : sq_shift[RW+1:0];
  assign root_nxt = {root_r[RW-2:0], sq_ge};
  assign root_sat = (|root_nxt[RW-1:VW]) ? {VW{1'b1}} : root_nxt[VW-1:0];

  assign ad_minus_vv = ad_r - vv_r;
  assign e1_sum      = W'(ta_r) + W'(tc_r);

  // sequencer: products, compare, a division, then a second division or two roots, then constant terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_r  <= VW'(1) << F;
      amax_r  <= VW'(1) << (F - 1);
      dist_r  <= VW'(2) << F;
      state_r <= ST_VV;
      cnt_r   <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        tmp_pkg::REG_MAX_VEL: vmax_r <= cfg_data;
        tmp_pkg::REG_MAX_ACC: amax_r <= cfg_data;
        default:              dist_r <= cfg_data;
      endcase
      state_r <= ST_VV;
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_VV: begin
          vv_r    <= mul_p;
          state_r <= ST_AD;
        end
        ST_AD: begin
          ad_r    <= mul_p;
          state_r <= ST_AV;
        end
        ST_AV: begin
          av_r    <= mul_p;
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          tri_r <= vv_r > ad_r;
          cnt_r <= '0;
          rem_r <= '0;
          dv_r  <= DW'(a_use);
          if (vv_r > ad_r)
            n_r <= {{(QW-VW-2*F){1'b0}}, dist_r, {(2*F){1'b0}}};
          else
            n_r <= {{(QW-VW-F){1'b0}}, v_eff, {F{1'b0}}};
          state_r <= ST_DIV1;
        end
        ST_DIV1: begin
          n_r   <= n_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(QW - 1)) begin
            cnt_r <= '0;
            if (tri_r) begin
              sx_r    <= n_nxt;
              sr_r    <= '0;
              root_r  <= '0;
              state_r <= ST_SQ1;
            end else begin
              ta_r    <= q_sat;
              n_r     <= {{(QW-DW-F){1'b0}}, ad_minus_vv, {F{1'b0}}};
              rem_r   <= '0;
              dv_r    <= av_r;
              state_r <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          n_r   <= n_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(QW - 1)) begin
            tc_r    <= q_sat;
            pk_r    <= v_eff;
            state_r <= ST_AT;
          end
        end
        ST_SQ1: begin
          sx_r   <= {sx_r[QW-3:0], 2'b00};
          sr_r   <= sr_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(RW - 1)) begin
            ta_r    <= root_sat;
            sx_r    <= {{(QW-DW){1'b0}}, ad_r};
            sr_r    <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= ST_SQ2;
          end
        end
        ST_SQ2: begin
          sx_r   <= {sx_r[QW-3:0], 2'b00};
          sr_r   <= sr_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == CW'(RW - 1)) begin
            pk_r    <= root_nxt[VW-1:0];
            tc_r    <= '0;
            state_r <= ST_AT;
          end
        end
        ST_AT: begin
          at_r    <= mul_p;
          state_r <= ST_ATLO;
        end
        ST_ATLO: begin
          part_r  <= mul_p;
          state_r <= ST_ATHI;
        end
        ST_ATHI: begin
          ata2_r  <= {mul_p, {VW{1'b0}}} + (3*VW)'(part_r);
          e1_r    <= e1_sum;
          e2_r    <= (W+1)'(e1_sum) + (W+1)'(ta_r);
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign a_eff     = a_use;
  assign move_dist = dist_r;
  assign ta        = ta_r;
  assign peak      = pk_r;
  assign e1        = e1_r;
  assign e2        = e2_r;
  assign ata2      = ata2_r;
  assign tri_flag  = tri_r;

endmodule

// ----- rtl/tmp_eval.sv -----
module tmp_eval #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_take,
  input  logic [W-1:0]                       sample_time,
  input  logic [W-2:0]                       a_eff,
  input  logic [W-2:0]                       move_dist,
  input  logic [W-2:0]                       ta,
  input  logic [W-2:0]                       peak,
  input  logic [W-1:0]                       e1,
  input  logic [W:0]                         e2,
  input  logic [3*(W-1)-1:0]                 ata2,
  input  logic                               tri_flag,
  output logic                               res_valid,
  output logic [W-2:0]                       res_position,
  output logic [W-2:0]                       res_velocity,
  output logic [W-1:0]                       res_accel,
  output logic [tmp_pkg::PHASE_W-1:0]        res_phase
);

  localparam int VW = W - 1;
  localparam int DW = 2 * VW;
  localparam int XW = 2 * VW + F;
  localparam int SW = 3 * VW + F + 3;
  localparam int SH = 2 * F + 1;
  localparam int PW = tmp_pkg::PHASE_W;

  logic          s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic [PW-1:0] s1_ph_r, s2_ph_r, s3_ph_r, s4_ph_r, out_ph_r;
  logic [VW-1:0] s1_x_r, s2_x_r;
  logic [DW-1:0] s2_ax_r, s2_px_r, s3_lo_r, s3_hi_r, s3_px_r;
  logic [VW-1:0] s3_vel_r, s4_vel_r, out_vel_r, out_pos_r;
  logic [SW-1:0] s4_sum_r;
  logic          s4_neg_r;
  logic [W-1:0]  out_acc_r;

  logic          t_pos;
  logic [VW-1:0] tv, x1;
  logic [PW-1:0] ph1;
  logic [DW-1:0] ax_p, px_p, lo_p, hi_p;
  logic [XW-1:0] ax_ext, pf_ext, acc_sh, dec_sh;
  logic [VW-1:0] vel3;
  logic [SW-1:0] axx, term_p, d_sh, ata_ext, plus, minus, sum4;
  logic          neg4;
  logic [VW-1:0] pos_sat, pos5;
  logic [W-1:0]  acc5;

  // stage 1: sort the time into a phase and take the time within it
  assign t_pos = !sample_time[W-1] && (|sample_time[W-2:0]);
  assign tv    = sample_time[VW-1:0];
  always_comb begin
    priority if (!t_pos) begin
      ph1 = tmp_pkg::PH_STAND;   x1 = '0;
    end else if (tv <= ta) begin
      ph1 = tmp_pkg::PH_ACCEL;   x1 = tv;
    end else if (!tri_flag && W'(tv) <= e1) begin
      ph1 = tmp_pkg::PH_CRUISE;  x1 = tv - ta;
    end else if ((W+1)'(tv) <= e2) begin
      ph1 = tmp_pkg::PH_DECEL;   x1 = tv - e1[VW-1:0];
    end else begin
      ph1 = tmp_pkg::PH_REACHED; x1 = '0;
    end
  end

  // stage 2: a*x and p*x
  assign ax_p = DW'(a_eff) * DW'(s1_x_r);
  assign px_p = DW'(peak) * DW'(s1_x_r);

  // stage 3: a*x*x in two halves, velocity
  assign lo_p   = DW'(s2_ax_r[VW-1:0]) * DW'(s2_x_r);
  assign hi_p   = DW'(s2_ax_r[DW-1:VW]) * DW'(s2_x_r);
  assign ax_ext = XW'(s2_ax_r);
  assign pf_ext = {{(XW-VW-F){1'b0}}, peak, {F{1'b0}}};
  assign acc_sh = ax_ext >> F;
  assign dec_sh = (pf_ext - ax_ext) >> F;
  always_comb begin
    unique case (s2_ph_r)
      tmp_pkg::PH_ACCEL:  vel3 = (|acc_sh[XW-1:VW]) ? {VW{1'b1}} : acc_sh[VW-1:0];
      tmp_pkg::PH_CRUISE: vel3 = peak;
      tmp_pkg::PH_DECEL: begin
        if (ax_ext >= pf_ext)
          vel3 = '0;
        else
          vel3 = (|dec_sh[XW-1:VW]) ? {VW{1'b1}} : dec_sh[VW-1:0];
      end
      default:            vel3 = '0;
    endcase
  end

  // stage 4: gather the position numerator
  assign axx     = {{(SW-3*VW){1'b0}}, s3_hi_r, {VW{1'b0}}} + SW'(s3_lo_r);
  assign term_p  = {{(SW-DW-F-1){1'b0}}, s3_px_r, {(F+1){1'b0}}};
  assign d_sh    = {{(SW-VW-SH){1'b0}}, move_dist, {SH{1'b0}}};
  assign ata_ext = SW'(ata2);
  assign plus    = d_sh + term_p;
  assign minus   = ata_ext + axx;
  always_comb begin
    unique case (s3_ph_r)
      tmp_pkg::PH_ACCEL:  begin sum4 = axx;              neg4 = 1'b0;           end
      tmp_pkg::PH_CRUISE: begin sum4 = ata_ext + term_p; neg4 = 1'b0;           end
      tmp_pkg::PH_DECEL:  begin sum4 = plus - minus;     neg4 = plus <= minus;  end
      default:            begin sum4 = '0;               neg4 = 1'b0;           end
    endcase
  end

  // stage 5: scale, saturate and clamp to the distance
  assign pos_sat = (|s4_sum_r[SW-1:VW+SH]) ? {VW{1'b1}} : s4_sum_r[VW+SH-1:SH];
  always_comb begin
    unique case (s4_ph_r)
      tmp_pkg::PH_ACCEL:   begin pos5 = pos_sat;    acc5 = W'(a_eff);        end
      tmp_pkg::PH_CRUISE:  begin pos5 = pos_sat;    acc5 = '0;               end
      tmp_pkg::PH_DECEL:   begin
        pos5 = s4_neg_r ? '0 : pos_sat;
        acc5 = W'(0) - W'(a_eff);
      end
      tmp_pkg::PH_REACHED: begin pos5 = move_dist;  acc5 = '0;               end
      default:             begin pos5 = '0;         acc5 = '0;               end
    endcase
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_take;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // advance the data of every stage
  always_ff @(posedge clk) begin
    s1_ph_r   <= ph1;
    s1_x_r    <= x1;
    s2_ph_r   <= s1_ph_r;
    s2_x_r    <= s1_x_r;
    s2_ax_r   <= ax_p;
    s2_px_r   <= px_p;
    s3_ph_r   <= s2_ph_r;
    s3_lo_r   <= lo_p;
    s3_hi_r   <= hi_p;
    s3_px_r   <= s2_px_r;
    s3_vel_r  <= vel3;
    s4_ph_r   <= s3_ph_r;
    s4_sum_r  <= sum4;
    s4_neg_r  <= neg4;
    s4_vel_r  <= s3_vel_r;
    out_ph_r  <= s4_ph_r;
    out_pos_r <= (pos5 > move_dist) ? move_dist : pos5;
    out_vel_r <= s4_vel_r;
    out_acc_r <= acc5;
  end

  assign res_valid    = out_v_r;
  assign res_position = out_pos_r;
  assign res_velocity = out_vel_r;
  assign res_accel    = out_acc_r;
  assign res_phase    = out_ph_r;

endmodule

// ----- rtl/trapezoidal_motion_profile_top.sv -----
// Trapezoidal motion profile setpoint generator, Q(FRAC_BITS) fixed point (Q16.16 in 32 bits by default).
// Configuration: write cfg_data to cfg_index while cfg_we is high; index 0
// sets the velocity limit, 1 the acceleration limit, 2 the move distance,
// other indexes are ignored. Each write of a known index re-derives the
// plan (accel time, cruise time, peak velocity, triangle flag).
// Planning runs on one shared multiplier, a bit-serial divider and a
// two-bits-a-step root unit after the write; busy is high throughout.
// Input: a time word is accepted on a clock edge with start high and busy
// low. Any number of words can follow one per cycle while busy stays low.
// Result: out_valid strobes for one cycle, with position, velocity,
// acceleration and phase. The receiver cannot stall; one result
// leaves every cycle at full rate.
// Reset: restores limits 1.0 m/s, 0.5 m/s^2 and distance 2.0 m, empties
// the pipeline and plans once before busy falls.
module trapezoidal_motion_profile_top #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [WORD_WIDTH-1:0]         in_sample_time,
  output logic                                 out_valid,
  output logic [WORD_WIDTH-2:0]                out_position,
  output logic [WORD_WIDTH-2:0]                out_velocity,
  output logic signed [WORD_WIDTH-1:0]         out_acceleration,
  output logic [tmp_pkg::PHASE_W-1:0]          out_phase,
  input  logic                                 cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [WORD_WIDTH-2:0]                cfg_data
);

  localparam int W  = WORD_WIDTH;
  localparam int VW = W - 1;

  logic              plan_busy, tri_flag, take;
  logic [VW-1:0]     a_eff, move_dist, ta, peak;
  logic [W-1:0]      e1;
  logic [W:0]        e2;
  logic [3*VW-1:0]   ata2;

  tmp_plan #(.W(W), .F(FRAC_BITS)) u_plan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (plan_busy),
    .a_eff    (a_eff),
    .move_dist(move_dist),
    .ta       (ta),
    .peak     (peak),
    .e1       (e1),
    .e2       (e2),
    .ata2     (ata2),
    .tri_flag (tri_flag)
  );

  // take a word when the plan is settled
  assign take = start && !plan_busy;
  assign busy = plan_busy;

  tmp_eval #(.W(W), .F(FRAC_BITS)) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (take),
    .sample_time (in_sample_time),
    .a_eff       (a_eff),
    .move_dist   (move_dist),
    .ta          (ta),
    .peak        (peak),
    .e1          (e1),
    .e2          (e2),
    .ata2        (ata2),
    .tri_flag    (tri_flag),
    .res_valid   (out_valid),
    .res_position(out_position),
    .res_velocity(out_velocity),
    .res_accel   (out_acceleration),
    .res_phase   (out_phase)
  );

endmodule

// ----- rtl/tmp_checker.sv -----
module tmp_checker #(
  parameter int WORD_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [WORD_WIDTH-2:0]             out_position,
  input logic [WORD_WIDTH-2:0]             out_velocity,
  input logic [WORD_WIDTH-1:0]             out_acceleration,
  input logic [tmp_pkg::PHASE_W-1:0]       out_phase,
  input logic                              cfg_we,
  input logic [tmp_pkg::CFG_IDX_W-1:0]     cfg_index
);

  // every accepted word gives its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(tmp_pkg::EVAL_LATENCY) out_valid)
    else $error("result strobe missing after accepted word");

  // known register writes always re-plan
  a_replan: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == tmp_pkg::REG_MAX_VEL || cfg_index == tmp_pkg::REG_MAX_ACC ||
               cfg_index == tmp_pkg::REG_DIST) |=> busy)
    else $error("no re-plan after register write");

  // standstill carries no motion
  a_stand: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == tmp_pkg::PH_STAND |->
      out_position == '0 && out_velocity == '0 && out_acceleration == '0)
    else $error("motion reported at standstill");

  // target reached holds still
  a_reached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == tmp_pkg::PH_REACHED |->
      out_velocity == '0 && out_acceleration == '0)
    else $error("motion reported after target reached");

  // accelerating means a positive acceleration
  a_accel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == tmp_pkg::PH_ACCEL |->
      !out_acceleration[WORD_WIDTH-1] && out_acceleration != '0)
    else $error("accel phase without positive acceleration");

endmodule

bind trapezoidal_motion_profile_top tmp_checker #(.WORD_WIDTH(WORD_WIDTH)) u_tmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_position    (out_position),
  .out_velocity    (out_velocity),
  .out_acceleration(out_acceleration),
  .out_phase       (out_phase),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index)
);
